// ===== hdl/health_breaker_backoff_defines.svh =====
// assertion macros for the health breaker
`ifndef HEALTH_BREAKER_BACKOFF_DEFINES_SVH
`define HEALTH_BREAKER_BACKOFF_DEFINES_SVH

`ifndef SYNTH
// check that holds once reset is released
`define HBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds around reset
`define HBB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBB_ASSERT(lbl, prop, msg)
`define HBB_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hdl/hbb_pkg.sv =====
`default_nettype none

package hbb_pkg;

  // defaults for the top level parameters
  localparam int WINDOW_MAX_DEF = 32;
  localparam int TIME_BITS_DEF  = 48;

  // fixed field widths
  localparam int GEN_W      = 32;
  localparam int MS_W       = 32;
  localparam int WS_W       = 6;
  localparam int Q8_W       = 16;
  localparam int FAIL_OUT_W = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // request codes
  localparam logic REQ_PROBE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result transition codes
  typedef enum logic [1:0] {
    TR_NONE      = 2'd0,
    TR_UNHEALTHY = 2'd1,
    TR_HEALTHY   = 2'd2
  } trans_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE       = 3'd0,
    CFG_FAILURE_THRESHOLD = 3'd1,
    CFG_STABLE_AFTER      = 3'd2,
    CFG_INITIAL_COOLDOWN  = 3'd3,
    CFG_MAX_COOLDOWN      = 3'd4,
    CFG_BACKOFF_Q8        = 3'd5
  } cfg_idx_t;

  // reset values of the configuration registers
  localparam logic [WS_W-1:0] RST_WINDOW_SIZE       = 6'd8;
  localparam logic [WS_W-1:0] RST_FAILURE_THRESHOLD = 6'd3;
  localparam logic [MS_W-1:0] RST_STABLE_AFTER      = 32'd60000;
  localparam logic [MS_W-1:0] RST_INITIAL_COOLDOWN  = 32'd1000;
  localparam logic [MS_W-1:0] RST_MAX_COOLDOWN      = 32'd60000;
  localparam logic [Q8_W-1:0] RST_BACKOFF_Q8        = 16'd512;

  typedef struct packed {
    logic [WS_W-1:0] window_size;
    logic [WS_W-1:0] failure_threshold;
    logic [MS_W-1:0] stable_after_ms;
    logic [MS_W-1:0] initial_cooldown_ms;
    logic [MS_W-1:0] max_cooldown_ms;
    logic [Q8_W-1:0] backoff_q8;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/hbb_ifs.sv =====
`default_nettype none

// probe / query request channel
interface hbb_in_if #(
  parameter int TIME_BITS = hbb_pkg::TIME_BITS_DEF
);
  import hbb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic                 probe_ok;
  logic [GEN_W-1:0]     probe_gen;
  logic [TIME_BITS-1:0] start_ms;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, req_type, probe_ok, probe_gen, start_ms, now_ms,
                  input ready);
  modport sink   (input valid, req_type, probe_ok, probe_gen, start_ms, now_ms,
                  output ready);
endinterface

// status result channel
interface hbb_out_if;
  import hbb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  accepted;
  logic [1:0]            transition;
  logic                  is_healthy;
  logic [GEN_W-1:0]      cur_gen;
  logic [MS_W-1:0]       cooldown_left_ms;
  logic [FAIL_OUT_W-1:0] window_failures;

  modport source (output valid, accepted, transition, is_healthy, cur_gen,
                  cooldown_left_ms, window_failures, input ready);
  modport sink   (input valid, accepted, transition, is_healthy, cur_gen,
                  cooldown_left_ms, window_failures, output ready);
endinterface

`default_nettype wire

// ===== hdl/health_breaker_backoff.sv =====
// channel  direction  handshake          payload
// in_ch    in         valid/ready        req_type probe_ok probe_gen start_ms now_ms
// out_ch   out        valid/ready        accepted transition is_healthy cur_gen
//                                        cooldown_left_ms window_failures
// cfg_*    in         cfg_we, no wait    cfg_idx cfg_wdata
//
// one item per cycle while out_ch is not stalled: a request is held in the
// input register, the window, trip and recovery logic settle the state from
// it, and the result then lands in the output register.
// reset is synchronous and active low; no clearing pass.
// a stalled result holds the output register; the input register still
// drains into it as soon as it frees up, so one item can wait on each side.
// the backed-off cooldown comes from a registered multiplier that follows
// the current cooldown in the cycle after it changes.
`default_nettype none

`include "health_breaker_backoff_defines.svh"

module health_breaker_backoff #(
  parameter int WINDOW_MAX = hbb_pkg::WINDOW_MAX_DEF,
  parameter int TIME_BITS  = hbb_pkg::TIME_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  hbb_in_if.sink                              in_ch,
  hbb_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [hbb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [hbb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hbb_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int EW_W  = (CNT_W > WS_W) ? CNT_W : WS_W;

  cfg_t cfg;

  // input register
  logic                 in_v_r;
  logic                 req_r;
  logic                 ok_r;
  logic [GEN_W-1:0]     probe_gen_r;
  logic [TIME_BITS-1:0] start_r;
  logic [TIME_BITS-1:0] now_r;

  // breaker state
  logic                  healthy_r, healthy_nxt;
  logic [GEN_W-1:0]      gen_r, gen_nxt;
  logic [WINDOW_MAX-1:0] win_r, win_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]      fail_r, fail_nxt;
  logic [MS_W-1:0]       cooldown_r, cooldown_nxt;
  logic [TIME_BITS-1:0]  recover_r, recover_nxt;
  logic [TIME_BITS-1:0]  recovered_r, recovered_nxt;
  logic                  rec_valid_r, rec_valid_nxt;

  // result register
  logic                  out_v_r, out_v_nxt;
  logic                  o_accepted_r;
  trans_t                o_trans_r;
  logic                  o_healthy_r;
  logic [GEN_W-1:0]      o_gen_r;
  logic [MS_W-1:0]       o_left_r;
  logic [FAIL_OUT_W-1:0] o_fail_r;

  // datapath
  logic                  out_free;
  logic                  adv;
  logic                  in_rdy;
  logic                  probe_hit;
  logic                  trip;
  logic                  heal;
  logic [WINDOW_MAX-1:0] w_bits;
  logic [CNT_W-1:0]      w_fill;
  logic [CNT_W-1:0]      w_fail;
  logic                  w_full;
  logic [MS_W-1:0]       next_cd;
  logic                  backoff_sel;
  logic [MS_W-1:0]       cd_new;
  logic [TIME_BITS-1:0]  room;
  logic                  rec_sat;
  logic [TIME_BITS-1:0]  rec_new;
  logic [TIME_BITS-1:0]  left_diff;
  logic [63:0]           left_ext;
  logic [MS_W-1:0]       left_ms;
  trans_t                trans_nxt;

  hbb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hbb_backoff u_backoff (
    .clk           (clk),
    .cfg           (cfg),
    .cooldown_cur  (cooldown_r),
    .next_cooldown (next_cd)
  );

  hbb_window #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_window (
    .bits_cur    (win_r),
    .fill_cur    (fill_r),
    .fail_bit    (!ok_r),
    .window_size (cfg.window_size),
    .bits_nxt    (w_bits),
    .fill_nxt    (w_fill),
    .fail_nxt    (w_fail),
    .full        (w_full)
  );

  // flow control
  assign out_free = !out_v_r || out_ch.ready;
  assign adv      = in_v_r && out_free;
  assign in_rdy   = !in_v_r || out_free;
  assign in_ch.ready = in_rdy;

  // trip and recovery decisions
  always_comb begin
    probe_hit = (req_r == REQ_PROBE) && (probe_gen_r == gen_r);
    trip = probe_hit && healthy_r && (EW_W'(w_fail) >= EW_W'(cfg.failure_threshold));
    heal = probe_hit && !healthy_r && ok_r && (start_r >= recover_r) && w_full &&
           (w_fail == '0);
  end

  // new cooldown and recovery time on a trip
  always_comb begin
    backoff_sel = rec_valid_r &&
                  (((now_r < recovered_r) && (cfg.stable_after_ms != '0)) ||
                   ((now_r - recovered_r) < TIME_BITS'(cfg.stable_after_ms)));
    cd_new  = backoff_sel ? next_cd : cfg.initial_cooldown_ms;
    room    = ~now_r;
    rec_sat = TIME_BITS'(cd_new) > room;
    rec_new = rec_sat ? '1 : (now_r + TIME_BITS'(cd_new));
  end

  // next state
  always_comb begin
    healthy_nxt   = healthy_r;
    gen_nxt       = gen_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    fail_nxt      = fail_r;
    cooldown_nxt  = cooldown_r;
    recover_nxt   = recover_r;
    recovered_nxt = recovered_r;
    rec_valid_nxt = rec_valid_r;
    trans_nxt     = TR_NONE;
    if (trip) begin
      healthy_nxt  = 1'b0;
      gen_nxt      = gen_r + GEN_W'(1);
      win_nxt      = '0;
      fill_nxt     = '0;
      fail_nxt     = '0;
      cooldown_nxt = cd_new;
      recover_nxt  = rec_new;
      trans_nxt    = TR_UNHEALTHY;
    end else if (probe_hit) begin
      win_nxt  = w_bits;
      fill_nxt = w_fill;
      fail_nxt = w_fail;
      if (heal) begin
        healthy_nxt   = 1'b1;
        gen_nxt       = gen_r + GEN_W'(1);
        recovered_nxt = now_r;
        rec_valid_nxt = 1'b1;
        trans_nxt     = TR_HEALTHY;
      end
    end
  end

  // remaining cooldown after this item
  always_comb begin
    left_diff = recover_r - now_r;
    left_ext  = 64'(left_diff);
    if (trip) begin
      left_ms = rec_sat ? room[MS_W-1:0] : cd_new;
    end else if (healthy_nxt || (now_r >= recover_r)) begin
      left_ms = '0;
    end else if (|left_ext[63:MS_W]) begin
      left_ms = '1;
    end else begin
      left_ms = left_ext[MS_W-1:0];
    end
  end

  // result valid
  always_comb begin
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_rdy) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      req_r       <= in_ch.req_type;
      ok_r        <= in_ch.probe_ok;
      probe_gen_r <= in_ch.probe_gen;
      start_r     <= in_ch.start_ms;
      now_r       <= in_ch.now_ms;
    end
  end

  // breaker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      healthy_r   <= 1'b1;
      gen_r       <= '0;
      win_r       <= '0;
      fill_r      <= '0;
      fail_r      <= '0;
      cooldown_r  <= '0;
      recover_r   <= '0;
      recovered_r <= '0;
      rec_valid_r <= 1'b0;
    end else if (adv) begin
      healthy_r   <= healthy_nxt;
      gen_r       <= gen_nxt;
      win_r       <= win_nxt;
      fill_r      <= fill_nxt;
      fail_r      <= fail_nxt;
      cooldown_r  <= cooldown_nxt;
      recover_r   <= recover_nxt;
      recovered_r <= recovered_nxt;
      rec_valid_r <= rec_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_accepted_r <= probe_hit;
      o_trans_r    <= trans_nxt;
      o_healthy_r  <= healthy_nxt;
      o_gen_r      <= gen_nxt;
      o_left_r     <= left_ms;
      o_fail_r     <= FAIL_OUT_W'(fail_nxt);
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.accepted         = o_accepted_r;
  assign out_ch.transition       = o_trans_r;
  assign out_ch.is_healthy       = o_healthy_r;
  assign out_ch.cur_gen          = o_gen_r;
  assign out_ch.cooldown_left_ms = o_left_r;
  assign out_ch.window_failures  = o_fail_r;

  // checks
  `HBB_ASSERT(a_gen_step, (adv && (trip || heal)) |=> (gen_r == $past(gen_r) + GEN_W'(1)), "generation did not step on a transition")
  `HBB_ASSERT(a_trip_clears, (adv && trip) |=> (fill_r == '0 && fail_r == '0 && !healthy_r), "trip left window or health stale")
  `HBB_ASSERT(a_fail_in_fill, (fail_r <= fill_r), "failure count exceeds window fill")
  `HBB_ASSERT_RST(a_reset_empty, (!rst_n) |=> (!out_v_r && !in_v_r), "reset left an item in flight")

endmodule

`default_nettype wire

// ===== hdl/hbb_cfg_regs.sv =====
`default_nettype none

module hbb_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hbb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [hbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output hbb_pkg::cfg_t                       cfg
);
  import hbb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_WINDOW_SIZE:       cfg_nxt.window_size         = cfg_wdata[WS_W-1:0];
        CFG_FAILURE_THRESHOLD: cfg_nxt.failure_threshold   = cfg_wdata[WS_W-1:0];
        CFG_STABLE_AFTER:      cfg_nxt.stable_after_ms     = cfg_wdata[MS_W-1:0];
        CFG_INITIAL_COOLDOWN:  cfg_nxt.initial_cooldown_ms = cfg_wdata[MS_W-1:0];
        CFG_MAX_COOLDOWN:      cfg_nxt.max_cooldown_ms     = cfg_wdata[MS_W-1:0];
        CFG_BACKOFF_Q8:        cfg_nxt.backoff_q8          = cfg_wdata[Q8_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size         <= RST_WINDOW_SIZE;
      cfg_r.failure_threshold   <= RST_FAILURE_THRESHOLD;
      cfg_r.stable_after_ms     <= RST_STABLE_AFTER;
      cfg_r.initial_cooldown_ms <= RST_INITIAL_COOLDOWN;
      cfg_r.max_cooldown_ms     <= RST_MAX_COOLDOWN;
      cfg_r.backoff_q8          <= RST_BACKOFF_Q8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/hbb_backoff.sv =====
`default_nettype none

// next backed-off cooldown, kept ready in the cycle after the cooldown changes
module hbb_backoff (
  input  wire logic                     clk,
  input  wire hbb_pkg::cfg_t            cfg,
  input  wire logic [hbb_pkg::MS_W-1:0] cooldown_cur,
  output logic      [hbb_pkg::MS_W-1:0] next_cooldown
);
  import hbb_pkg::*;

  localparam int PROD_W = MS_W + Q8_W;
  localparam int SHR_W  = PROD_W - 8;

  logic [PROD_W-1:0] prod;
  logic [SHR_W-1:0]  scaled;
  logic [MS_W-1:0]   next_cd_nxt;
  logic [MS_W-1:0]   next_cd_r;

  // q8.8 multiply, truncate, cap
  always_comb begin
    prod   = PROD_W'(cooldown_cur) * PROD_W'(cfg.backoff_q8);
    scaled = prod[PROD_W-1:8];
    if (scaled < SHR_W'(cfg.max_cooldown_ms)) begin
      next_cd_nxt = scaled[MS_W-1:0];
    end else begin
      next_cd_nxt = cfg.max_cooldown_ms;
    end
  end

  always_ff @(posedge clk) begin
    next_cd_r <= next_cd_nxt;
  end

  assign next_cooldown = next_cd_r;

endmodule

`default_nettype wire

// ===== hdl/hbb_window.sv =====
`default_nettype none

// sliding pass/fail window update for one accepted probe
module hbb_window #(
  parameter int WINDOW_MAX = hbb_pkg::WINDOW_MAX_DEF,
  localparam int CNT_W = $clog2(WINDOW_MAX + 1)
) (
  input  wire logic [WINDOW_MAX-1:0]    bits_cur,
  input  wire logic [CNT_W-1:0]         fill_cur,
  input  wire logic                     fail_bit,
  input  wire logic [hbb_pkg::WS_W-1:0] window_size,
  output logic      [WINDOW_MAX-1:0]    bits_nxt,
  output logic      [CNT_W-1:0]         fill_nxt,
  output logic      [CNT_W-1:0]         fail_nxt,
  output logic                          full
);
  import hbb_pkg::*;

  localparam int EW_W = (CNT_W > WS_W) ? CNT_W : WS_W;

  logic [EW_W-1:0]       ws_ext;
  logic [EW_W-1:0]       eff_ext;
  logic [CNT_W-1:0]      eff;
  logic [CNT_W:0]        fill_inc;
  logic [WINDOW_MAX-1:0] shifted;

  // effective window size, clamped to 1..WINDOW_MAX
  always_comb begin
    ws_ext = EW_W'(window_size);
    if (ws_ext == '0) begin
      eff_ext = EW_W'(1);
    end else if (ws_ext > EW_W'(WINDOW_MAX)) begin
      eff_ext = EW_W'(WINDOW_MAX);
    end else begin
      eff_ext = ws_ext;
    end
    eff = eff_ext[CNT_W-1:0];
  end

  // fill count grows up to the window size
  always_comb begin
    fill_inc = {1'b0, fill_cur} + (CNT_W + 1)'(1);
    if (fill_inc > {1'b0, eff}) begin
      fill_nxt = eff;
    end else begin
      fill_nxt = fill_inc[CNT_W-1:0];
    end
    full = (fill_nxt == eff);
  end

  // shift in newest result, drop anything past the fill
  always_comb begin
    shifted = (bits_cur << 1) | WINDOW_MAX'(fail_bit);
    for (int i = 0; i < WINDOW_MAX; i++) begin
      bits_nxt[i] = shifted[i] & (CNT_W'(i) < fill_nxt);
    end
    fail_nxt = CNT_W'($countones(bits_nxt));
  end

endmodule

`default_nettype wire
